// ----- hdl/sva_pkg.sv -----
// Shared types, codes and sizes of the synthesizer voice allocator.
package sva_pkg;

  localparam int VOICES  = 32;
  localparam int NOTES   = 128;
  localparam int VOICE_W = 5;
  localparam int NOTE_W  = 7;
  localparam int AGE_W   = 32;

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_FINISH   = 2'd2;
  localparam logic [1:0] KIND_APPLY    = 2'd3;

  localparam logic [1:0] CFG_POLYPHONY = 2'd0;
  localparam logic [1:0] CFG_UNISON    = 2'd1;
  localparam logic [1:0] CFG_MODE      = 2'd2;

  localparam logic [1:0] MODE_POLY    = 2'd0;
  localparam logic [1:0] MODE_HIGHEST = 2'd1;
  localparam logic [1:0] MODE_LOWEST  = 2'd2;
  localparam logic [1:0] MODE_NEWEST  = 2'd3;

  localparam logic [1:0] STAGE_OFF      = 2'd0;
  localparam logic [1:0] STAGE_RELEASED = 2'd1;
  localparam logic [1:0] STAGE_SOUNDING = 2'd2;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_OFF     = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [NOTE_W-1:0]  note;
    logic [6:0]         velocity;
    logic [VOICE_W-1:0] voice;
  } item_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice_index;
    logic [1:0]         action;
    logic [NOTE_W-1:0]  note_number;
    logic [6:0]         gate_level;
    logic signed [15:0] unison_spread;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_FINISH, OP_NOTE, OP_MONO, OP_RESTAMP, OP_DUP, OP_PREP,
    OP_DIV, OP_MOD, OP_PICK, OP_COMMIT, OP_REL, OP_OFF, OP_APPLY, OP_FLUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FINISH, S_NOTE, S_MONO, S_RESTAMP, S_DUP, S_PREP, S_DIV,
    S_MOD, S_PICK, S_COMMIT, S_REL, S_OFF, S_APPLY, S_FLUSH
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       mono;
    logic       scan_last;
    logic       dup_hit;
    logic       found;
    logic       more;
    logic       mod_done;
  } status_t;

endpackage

// ----- hdl/sva_ctrl.sv -----
// Sequencing state machine of the voice allocator.
module sva_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  input  sva_pkg::status_t  status,
  output logic              busy,
  output sva_pkg::cmd_t     cmd
);

  sva_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sva_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sva_pkg::S_IDLE: begin
        if (start) begin
          unique case (kind)
            sva_pkg::KIND_NOTE_ON:  state_next = sva_pkg::S_NOTE;
            sva_pkg::KIND_NOTE_OFF: state_next = sva_pkg::S_NOTE;
            sva_pkg::KIND_FINISH:   state_next = sva_pkg::S_FINISH;
            default:                state_next = sva_pkg::S_OFF;
          endcase
        end
      end
      sva_pkg::S_FINISH: state_next = sva_pkg::S_IDLE;
      sva_pkg::S_NOTE: begin
        if (status.mono) begin
          state_next = sva_pkg::S_MONO;
        end else if (status.kind == sva_pkg::KIND_NOTE_ON) begin
          state_next = sva_pkg::S_DUP;
        end else begin
          state_next = sva_pkg::S_REL;
        end
      end
      sva_pkg::S_MONO: begin
        if (status.scan_last) begin
          if (status.kind == sva_pkg::KIND_NOTE_ON) begin
            state_next = sva_pkg::S_DUP;
          end else if (status.found) begin
            state_next = sva_pkg::S_RESTAMP;
          end else begin
            state_next = sva_pkg::S_REL;
          end
        end
      end
      sva_pkg::S_RESTAMP: state_next = sva_pkg::S_DUP;
      sva_pkg::S_DUP: begin
        if (status.dup_hit) begin
          state_next = sva_pkg::S_FLUSH;
        end else if (status.scan_last) begin
          state_next = sva_pkg::S_PREP;
        end
      end
      sva_pkg::S_PREP: state_next = sva_pkg::S_DIV;
      sva_pkg::S_DIV: begin
        if (status.scan_last) state_next = sva_pkg::S_MOD;
      end
      sva_pkg::S_MOD: begin
        if (status.mod_done) state_next = sva_pkg::S_PICK;
      end
      sva_pkg::S_PICK: begin
        if (status.scan_last) state_next = sva_pkg::S_COMMIT;
      end
      sva_pkg::S_COMMIT: begin
        state_next = status.more ? sva_pkg::S_MOD : sva_pkg::S_FLUSH;
      end
      sva_pkg::S_REL: begin
        if (status.scan_last) state_next = sva_pkg::S_FLUSH;
      end
      sva_pkg::S_OFF: begin
        if (status.scan_last) state_next = sva_pkg::S_APPLY;
      end
      sva_pkg::S_APPLY: state_next = sva_pkg::S_FLUSH;
      sva_pkg::S_FLUSH: state_next = sva_pkg::S_IDLE;
      default: state_next = sva_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != sva_pkg::S_IDLE);
    unique case (state)
      sva_pkg::S_IDLE:    cmd.op = start ? sva_pkg::OP_LATCH : sva_pkg::OP_NONE;
      sva_pkg::S_FINISH:  cmd.op = sva_pkg::OP_FINISH;
      sva_pkg::S_NOTE:    cmd.op = sva_pkg::OP_NOTE;
      sva_pkg::S_MONO:    cmd.op = sva_pkg::OP_MONO;
      sva_pkg::S_RESTAMP: cmd.op = sva_pkg::OP_RESTAMP;
      sva_pkg::S_DUP:     cmd.op = sva_pkg::OP_DUP;
      sva_pkg::S_PREP:    cmd.op = sva_pkg::OP_PREP;
      sva_pkg::S_DIV:     cmd.op = sva_pkg::OP_DIV;
      sva_pkg::S_MOD:     cmd.op = sva_pkg::OP_MOD;
      sva_pkg::S_PICK:    cmd.op = sva_pkg::OP_PICK;
      sva_pkg::S_COMMIT:  cmd.op = sva_pkg::OP_COMMIT;
      sva_pkg::S_REL:     cmd.op = sva_pkg::OP_REL;
      sva_pkg::S_OFF:     cmd.op = sva_pkg::OP_OFF;
      sva_pkg::S_APPLY:   cmd.op = sva_pkg::OP_APPLY;
      sva_pkg::S_FLUSH:   cmd.op = sva_pkg::OP_FLUSH;
      default:            cmd.op = sva_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- hdl/sva_datapath.sv -----
// Note and voice state, scan units, spread divider and result registers.
module sva_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  sva_pkg::item_t    item,
  input  sva_pkg::cmd_t     cmd,
  output sva_pkg::status_t  status,
  output logic              result_strobe,
  output sva_pkg::result_t  result
);

  localparam logic [5:0] VMAX = 6'(sva_pkg::VOICES);

  // Configuration and applied settings.
  logic [5:0] polyphony, unison;
  logic [1:0] voice_mode;
  logic [1:0] applied_mode;
  logic [5:0] applied_unison, applied_voices;

  // Latched item and working values.
  sva_pkg::item_t itm;
  logic [6:0] tgt, tvel, held_vel;
  logic [7:0] cnt;

  // Note store: held flags in flops, ages in a memory.
  logic [sva_pkg::NOTES-1:0] note_valid;
  logic [sva_pkg::AGE_W-1:0] note_mem [sva_pkg::NOTES];
  logic [sva_pkg::AGE_W-1:0] mrd;
  logic                      mheld;
  logic [sva_pkg::AGE_W-1:0] note_seq, voice_seq;
  logic                      m_found;
  logic [6:0]                m_best;
  logic [sva_pkg::AGE_W-1:0] m_top;

  // Voice state.
  logic [sva_pkg::AGE_W-1:0] v_age   [sva_pkg::VOICES];
  logic [6:0]                v_pitch [sva_pkg::VOICES];
  logic [6:0]                v_gate  [sva_pkg::VOICES];
  logic [1:0]                v_stage [sva_pkg::VOICES];
  logic [4:0]                last_v;
  logic                      last_ok;

  // Spread stepping and voice search.
  logic [5:0]  div_rem, r, s, k;
  logic [16:0] quot, q;
  logic [4:0]  pidx, fbest, abest;
  logic        ff, af;
  logic [sva_pkg::AGE_W-1:0] fage, aage;

  // Result staging: one item is held back so that the final one can be marked.
  sva_pkg::result_t pend, push_res, pend_last;
  logic             pend_ok, push;

  logic [5:0] poly, uni, av, au, d, two_d;
  logic [4:0] sa, v_sel;
  logic [sva_pkg::AGE_W-1:0] eff_age;
  logic       all_off, mono_eval, mem_we, is_free, rel_hit, off_hit, ge, wrap;
  logic [6:0] e, mem_wa, rem_sh, r_sum;
  logic       found_n, ff_n, af_n;
  logic [6:0] best_n;
  logic [sva_pkg::AGE_W-1:0] top_n, fage_n, aage_n;
  logic [4:0] fbest_n, abest_n;
  logic [16:0] spread_w;

  always_comb begin
    poly = (polyphony == 6'd0) ? 6'd1 : ((polyphony > VMAX) ? VMAX : polyphony);
    uni  = (unison == 6'd0) ? 6'd1 : unison;
    if (uni > poly) uni = poly;
    av = (applied_voices == 6'd0) ? 6'd1 :
         ((applied_voices > VMAX) ? VMAX : applied_voices);
    au = (applied_unison == 6'd0) ? 6'd1 :
         ((applied_unison > VMAX) ? VMAX : applied_unison);
    d     = au - 6'd1;
    two_d = {d[4:0], 1'b0};
    sa    = (cmd.op == sva_pkg::OP_PICK) ? pidx : cnt[4:0];
    eff_age = (v_stage[sa] == sva_pkg::STAGE_OFF) ? '0 : v_age[sa];
    is_free = (v_stage[sa] != sva_pkg::STAGE_SOUNDING);
    all_off = (applied_mode != voice_mode);
    rel_hit = (cmd.op == sva_pkg::OP_REL) && (v_pitch[sa] == tgt) && (v_gate[sa] != 7'd0);
    off_hit = (cmd.op == sva_pkg::OP_OFF) && (({1'b0, cnt[4:0]} >= poly) || all_off);
    mem_we  = ((cmd.op == sva_pkg::OP_NOTE) && (itm.kind == sva_pkg::KIND_NOTE_ON)) ||
              (cmd.op == sva_pkg::OP_RESTAMP);
    mem_wa  = (cmd.op == sva_pkg::OP_RESTAMP) ? tgt : itm.note;
    v_sel   = ff ? fbest : abest;

    pend_last      = pend;
    pend_last.last = 1'b1;

    // Mono choice: one note entry per cycle, each evaluated in the cycle after its memory read.
    e         = cnt[6:0] - 7'd1;
    mono_eval = (cmd.op == sva_pkg::OP_MONO) && (cnt != 8'd0);
    found_n = m_found;
    best_n  = m_best;
    top_n   = m_top;
    if (mono_eval && mheld) begin
      found_n = 1'b1;
      unique case (voice_mode)
        sva_pkg::MODE_HIGHEST: best_n = e;
        sva_pkg::MODE_LOWEST: begin
          if (!m_found) best_n = e;
        end
        sva_pkg::MODE_NEWEST: begin
          if (mrd > m_top) begin
            top_n  = mrd;
            best_n = e;
          end
        end
        default: ;
      endcase
    end

    // Voice search: oldest free voice and oldest voice of any stage.
    ff_n = ff; fbest_n = fbest; fage_n = fage;
    af_n = af; abest_n = abest; aage_n = aage;
    if (is_free && (!ff || eff_age < fage)) begin
      ff_n = 1'b1; fbest_n = sa; fage_n = eff_age;
    end
    if (!af || eff_age < aage) begin
      af_n = 1'b1; abest_n = sa; aage_n = eff_age;
    end

    // Restoring divide of 65536 by 2(U-1), one quotient bit a cycle.
    rem_sh = {div_rem, (cnt == 8'd0)};
    ge     = (rem_sh >= {1'b0, two_d});
    r_sum  = {1'b0, r} + {1'b0, div_rem};
    wrap   = (r_sum >= {1'b0, two_d});
    spread_w = q - 17'd16384;

    push     = 1'b0;
    push_res = '0;
    unique case (cmd.op)
      sva_pkg::OP_COMMIT: begin
        push = 1'b1;
        push_res.voice_index   = v_sel;
        push_res.action        = sva_pkg::ACT_START;
        push_res.note_number   = tgt;
        push_res.gate_level    = tvel;
        push_res.unison_spread = (au == 6'd1) ? 16'sd0 : spread_w[15:0];
      end
      sva_pkg::OP_REL: begin
        push = rel_hit;
        push_res.voice_index = cnt[4:0];
        push_res.action      = sva_pkg::ACT_RELEASE;
        push_res.note_number = v_pitch[sa];
      end
      sva_pkg::OP_OFF: begin
        push = off_hit;
        push_res.voice_index = cnt[4:0];
        push_res.action      = sva_pkg::ACT_OFF;
        push_res.note_number = v_pitch[sa];
      end
      default: ;
    endcase

    status.kind      = itm.kind;
    status.mono      = (voice_mode != sva_pkg::MODE_POLY);
    status.dup_hit   = (cmd.op == sva_pkg::OP_DUP) && (v_pitch[sa] == tgt) &&
                       (v_gate[sa] != 7'd0);
    status.found     = found_n;
    status.more      = ((k + 6'd1) < au);
    status.mod_done  = (s < av);
    unique case (cmd.op)
      sva_pkg::OP_MONO: status.scan_last = (cnt == 8'(sva_pkg::NOTES));
      sva_pkg::OP_DUP:  status.scan_last = (cnt == {2'b00, poly} - 8'd1);
      sva_pkg::OP_REL:  status.scan_last = (cnt == {2'b00, poly} - 8'd1);
      sva_pkg::OP_OFF:  status.scan_last = (cnt == 8'(sva_pkg::VOICES - 1));
      sva_pkg::OP_DIV:  status.scan_last = (cnt == 8'd16);
      sva_pkg::OP_PICK: status.scan_last = (cnt == {2'b00, av} - 8'd1);
      default:          status.scan_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) note_mem[mem_wa] <= note_seq;
    mrd <= note_mem[cnt[6:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polyphony <= 6'd1;
      unison <= 6'd1;
      voice_mode <= sva_pkg::MODE_POLY;
      applied_mode <= sva_pkg::MODE_POLY;
      applied_unison <= 6'd1;
      applied_voices <= 6'd1;
      note_valid <= '0;
      note_seq <= 32'd1;
      voice_seq <= 32'd1;
      held_vel <= 7'd0;
      last_v <= 5'd0;
      last_ok <= 1'b0;
      cnt <= 8'd0;
      pend_ok <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < sva_pkg::VOICES; i++) begin
        v_age[i] <= '0;
        v_pitch[i] <= 7'd0;
        v_gate[i] <= 7'd0;
        v_stage[i] <= sva_pkg::STAGE_OFF;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sva_pkg::CFG_POLYPHONY: polyphony <= cfg_data;
          sva_pkg::CFG_UNISON:    unison <= cfg_data;
          sva_pkg::CFG_MODE:      voice_mode <= cfg_data[1:0];
          default: ;
        endcase
      end

      unique case (cmd.op)
        sva_pkg::OP_MONO, sva_pkg::OP_DUP, sva_pkg::OP_DIV, sva_pkg::OP_PICK,
        sva_pkg::OP_REL, sva_pkg::OP_OFF: cnt <= status.scan_last ? 8'd0 : cnt + 8'd1;
        default: cnt <= 8'd0;
      endcase

      if (mem_we && note_seq != '1) note_seq <= note_seq + 32'd1;
      mheld <= note_valid[cnt[6:0]];

      unique case (cmd.op)
        sva_pkg::OP_FINISH: begin
          v_stage[itm.voice] <= sva_pkg::STAGE_OFF;
          v_gate[itm.voice] <= 7'd0;
        end
        sva_pkg::OP_NOTE: begin
          note_valid[itm.note] <= (itm.kind == sva_pkg::KIND_NOTE_ON);
        end
        sva_pkg::OP_PREP: held_vel <= tvel;
        sva_pkg::OP_COMMIT: begin
          v_age[v_sel] <= voice_seq;
          if (voice_seq != '1) voice_seq <= voice_seq + 32'd1;
          v_pitch[v_sel] <= tgt;
          v_gate[v_sel] <= tvel;
          v_stage[v_sel] <= (tvel != 7'd0) ? sva_pkg::STAGE_SOUNDING
                                           : sva_pkg::STAGE_RELEASED;
          last_v <= v_sel;
          last_ok <= 1'b1;
        end
        sva_pkg::OP_REL: begin
          if (rel_hit) begin
            v_gate[sa] <= 7'd0;
            v_stage[sa] <= sva_pkg::STAGE_RELEASED;
            v_age[sa] <= voice_seq;
            if (voice_seq != '1) voice_seq <= voice_seq + 32'd1;
          end
        end
        sva_pkg::OP_OFF: begin
          if (off_hit) begin
            v_gate[sa] <= 7'd0;
            v_stage[sa] <= sva_pkg::STAGE_OFF;
          end
        end
        sva_pkg::OP_APPLY: begin
          applied_unison <= uni;
          applied_voices <= (voice_mode == sva_pkg::MODE_POLY) ? poly : uni;
          applied_mode <= voice_mode;
        end
        default: ;
      endcase

      result_strobe <= 1'b0;
      if (push) begin
        if (pend_ok) result_strobe <= 1'b1;
        pend_ok <= 1'b1;
      end else if (cmd.op == sva_pkg::OP_FLUSH && pend_ok) begin
        result_strobe <= 1'b1;
        pend_ok <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (push) begin
      pend <= push_res;
      result <= pend;
    end else if (cmd.op == sva_pkg::OP_FLUSH) begin
      result <= pend_last;
    end

    unique case (cmd.op)
      sva_pkg::OP_LATCH: itm <= item;
      sva_pkg::OP_NOTE: begin
        tgt <= itm.note;
        tvel <= itm.velocity;
        m_found <= 1'b0;
        m_best <= 7'd0;
        m_top <= '0;
      end
      sva_pkg::OP_MONO: begin
        m_found <= found_n;
        m_best <= best_n;
        m_top <= top_n;
        if (status.scan_last && found_n) begin
          tgt <= best_n;
          if (itm.kind == sva_pkg::KIND_NOTE_OFF) tvel <= held_vel;
        end
      end
      sva_pkg::OP_PREP: begin
        s <= last_ok ? {1'b0, last_v} + 6'd1 : 6'd0;
        k <= 6'd0;
        q <= 17'd0;
        r <= d;
        div_rem <= 6'd0;
        quot <= 17'd0;
      end
      sva_pkg::OP_DIV: begin
        div_rem <= ge ? 6'(rem_sh - {1'b0, two_d}) : rem_sh[5:0];
        quot <= {quot[15:0], ge};
      end
      sva_pkg::OP_MOD: begin
        if (s >= av) begin
          s <= s - av;
        end else begin
          pidx <= s[4:0];
          ff <= 1'b0;
          af <= 1'b0;
        end
      end
      sva_pkg::OP_PICK: begin
        ff <= ff_n; fbest <= fbest_n; fage <= fage_n;
        af <= af_n; abest <= abest_n; aage <= aage_n;
        pidx <= ({1'b0, pidx} + 6'd1 == av) ? 5'd0 : pidx + 5'd1;
      end
      sva_pkg::OP_COMMIT: begin
        s <= {1'b0, v_sel} + 6'd1;
        k <= k + 6'd1;
        q <= q + quot + {16'd0, wrap};
        r <= wrap ? 6'(r_sum - {1'b0, two_d}) : r_sum[5:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/synth_voice_allocator.sv -----
// Top level of the synthesizer voice allocator.
// One item is taken at a time: start is accepted when busy is low, and busy stays high
// until the item's last command has been issued. Commands appear on result for one cycle
// each, marked by result_strobe, and cannot be held off; result.last marks the final one.
// Most of an item's time goes to its scans: a mono note scans all 128 held-note ages,
// one per cycle from the age memory, and every note checks the voices in use for the same
// pitch. A spread divide runs once for each note that goes on to start voices, and each
// unison voice then takes a modulo step by repeated subtraction, which runs longer right
// after the voice count shrinks, and a search of the voices in use, one voice per cycle.
// No reset sweep is needed: held notes are tracked by flag bits cleared at reset.
module synth_voice_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sva_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [5:0]       cfg_data,
  output logic             result_strobe,
  output sva_pkg::result_t result
);

  sva_pkg::cmd_t    cmd;
  sva_pkg::status_t status;

  sva_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (item.kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  sva_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item          (item),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

  // Every command follows a cycle in which an item was being worked on.
  assert property (@(posedge clk) disable iff (rst) result_strobe |-> $past(busy))
    else $error("command issued with no item in progress");

  // An accepted item always occupies the block.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // The final command of an item is never directly followed by another.
  assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("command issued right after a final command");

endmodule
